// File: hw/rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds sizing, operation and status codes, and the request/response payloads.
// No dependencies.
package bba_pkg;

  localparam int BLOCK_COUNT = 1024;
  localparam int PTRS        = 16;
  localparam int MAX_RESULTS = 16;

  localparam int BLK_W   = 10;
  localparam int CNT_W   = 5;
  localparam int WORD_W  = 32;
  localparam int WORDS   = BLOCK_COUNT / WORD_W;
  localparam int WORD_AW = $clog2(WORDS);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int PTR_AW  = $clog2(PTRS);
  // Signed slot index: covers current_blocks + count and a step below zero.
  localparam int SLOT_W  = 7;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_GROW   = 2'd2,
    OP_SHRINK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] current_blocks;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    status_t          status;
    logic             last;
  } rsp_t;

endpackage

// File: hw/rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator: first-fit allocation over a
// word-organized used map in RAM plus a pointer table RAM. Uses bba_pkg, bba_ram.
//
//   channel | signals                  | payload
//   --------+--------------------------+--------------------------------------
//   request | req_valid, req_ready     | req  (op, block, count, current_blocks)
//   result  | rsp_valid, rsp_ready     | rsp  (block_number, status, last)
//
// One item at a time. Allocate steps FIND, AWR; free, CLWR; grow, per block,
// PCHK, FIND, AWR; shrink, per block, PCHK, PTRD, CLWR. Each block costs a
// read-modify-write of one used-map word on the map RAM's single read and
// write port. A summary register of full words picks the word to read, so no
// scan runs over the map. Reset clears per-word valid bits and the full
// summary at once; no clearing pass. A stalled result holds the sequencer; a
// new item is taken as soon as the last result sits in the output register.
module bitmap_block_allocator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bba_pkg::rsp_t rsp
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_AWR,
    S_PCHK,
    S_PTRD,
    S_CLWR,
    S_EMIT
  } state_t;

  state_t                   state;
  op_t                      op_q;
  logic [BLK_W-1:0]         blk_q;
  logic signed [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]         rem_q;
  logic [WORD_AW-1:0]       widx_q;
  status_t                  emit_st_q;
  logic [BLK_W-1:0]         emit_blk_q;
  logic [WORDS-1:0]         valid_q;
  logic [WORDS-1:0]         full_q;

  logic                  accept;
  logic                  rsp_free;
  logic                  rsp_load;
  logic                  any_free;
  logic [WORD_AW-1:0]    free_word;
  logic [WORD_W-1:0]     map_rdata;
  logic [WORD_W-1:0]     alloc_word;
  logic [WORD_W-1:0]     set_word;
  logic [BIT_W-1:0]      zpos;
  logic [BLK_W-1:0]      alloc_blk;
  logic [WORD_AW-1:0]    clr_widx;
  logic [WORD_W-1:0]     clr_word;
  logic                  blk_inrange;
  logic                  req_inrange;
  logic                  slot_bad;
  logic [CNT_W-1:0]      cnt_sat;
  logic [BLK_W-1:0]      ptr_rdata;

  logic                  map_we;
  logic [WORD_AW-1:0]    map_waddr;
  logic [WORD_W-1:0]     map_wdata;
  logic                  map_re;
  logic [WORD_AW-1:0]    map_raddr;
  logic                  ptr_we;
  logic                  ptr_re;

  assign accept      = req_valid && req_ready;
  assign req_ready   = (state == S_IDLE);
  assign rsp_free    = !rsp_valid || rsp_ready;
  assign rsp_load    = rsp_free && ((state == S_AWR) || (state == S_CLWR) || (state == S_EMIT));
  assign any_free    = !(&full_q);
  assign blk_inrange = int'(blk_q) < BLOCK_COUNT;
  assign req_inrange = int'(req.block) < BLOCK_COUNT;
  assign slot_bad    = slot_q[SLOT_W-1] || (slot_q >= $signed(SLOT_W'(PTRS)));
  assign cnt_sat     = (req.count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : req.count;

  // Lowest word with a free bit.
  always_comb begin
    free_word = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) free_word = WORD_AW'(i);
    end
  end

  // Lowest free bit of the fetched word; a never-written word reads as all free.
  always_comb begin
    alloc_word = valid_q[widx_q] ? map_rdata : '0;
    zpos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!alloc_word[i]) zpos = BIT_W'(i);
    end
    set_word  = alloc_word | (WORD_W'(1) << zpos);
    alloc_blk = {widx_q, zpos};
  end

  always_comb begin
    clr_widx = blk_q[BIT_W +: WORD_AW];
    clr_word = (valid_q[clr_widx] ? map_rdata : '0)
             & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
  end

  // Memory port control
  always_comb begin
    map_re    = 1'b0;
    map_raddr = free_word;
    map_we    = 1'b0;
    map_waddr = widx_q;
    map_wdata = set_word;
    ptr_we    = 1'b0;
    ptr_re    = 1'b0;
    unique case (state)
      S_IDLE: begin
        map_re    = accept && (req.op == OP_FREE);
        map_raddr = req.block[BIT_W +: WORD_AW];
      end
      S_FIND: begin
        map_re = any_free;
      end
      S_AWR: begin
        map_we = rsp_free;
        ptr_we = rsp_free && (op_q == OP_GROW);
      end
      S_PCHK: begin
        ptr_re = (op_q == OP_SHRINK) && !slot_bad;
      end
      S_PTRD: begin
        map_re    = 1'b1;
        map_raddr = ptr_rdata[BIT_W +: WORD_AW];
      end
      S_CLWR: begin
        map_we    = rsp_free && blk_inrange;
        map_waddr = clr_widx;
        map_wdata = clr_word;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (PTRS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (slot_q[PTR_AW-1:0]),
    .wdata (alloc_blk),
    .re    (ptr_re),
    .raddr (slot_q[PTR_AW-1:0]),
    .rdata (ptr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid_q   <= '0;
      full_q    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.op;
            rem_q <= cnt_sat;
            blk_q <= req.block;
            unique case (req.op)
              OP_ALLOC: state <= S_FIND;
              OP_FREE: begin
                if (req_inrange) begin
                  state <= S_CLWR;
                end else begin
                  emit_st_q  <= ST_RANGE;
                  emit_blk_q <= req.block;
                  state      <= S_EMIT;
                end
              end
              OP_GROW, OP_SHRINK: begin
                if (cnt_sat == '0) begin
                  emit_st_q  <= ST_NONE;
                  emit_blk_q <= '0;
                  state      <= S_EMIT;
                end else begin
                  if (req.op == OP_GROW) begin
                    slot_q <= (req.current_blocks == '0) ? '0
                            : $signed(SLOT_W'(req.current_blocks) - SLOT_W'(1));
                  end else begin
                    slot_q <= (req.current_blocks < CNT_W'(2)) ? '0
                            : $signed(SLOT_W'(req.current_blocks) - SLOT_W'(2));
                  end
                  state <= S_PCHK;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          if (any_free) begin
            widx_q <= free_word;
            state  <= S_AWR;
          end else begin
            emit_st_q  <= ST_NOSPACE;
            emit_blk_q <= '0;
            state      <= S_EMIT;
          end
        end
        S_AWR: begin
          if (rsp_free) begin
            valid_q[widx_q]   <= 1'b1;
            full_q[widx_q]    <= &set_word;
            rsp.block_number  <= alloc_blk;
            rsp.status        <= ST_OK;
            rsp.last          <= (op_q == OP_ALLOC) || (rem_q == CNT_W'(1));
            if ((op_q == OP_GROW) && (rem_q != CNT_W'(1))) begin
              rem_q  <= rem_q - CNT_W'(1);
              slot_q <= slot_q + SLOT_W'(1);
              state  <= S_PCHK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PCHK: begin
          if (slot_bad) begin
            emit_st_q  <= ST_RANGE;
            emit_blk_q <= '0;
            state      <= S_EMIT;
          end else if (op_q == OP_GROW) begin
            state <= S_FIND;
          end else begin
            state <= S_PTRD;
          end
        end
        S_PTRD: begin
          blk_q <= ptr_rdata;
          state <= S_CLWR;
        end
        S_CLWR: begin
          if (rsp_free) begin
            if (blk_inrange) begin
              valid_q[clr_widx] <= 1'b1;
              full_q[clr_widx]  <= 1'b0;
            end
            rsp.block_number <= blk_q;
            rsp.status       <= ST_OK;
            rsp.last         <= (op_q == OP_FREE) || (rem_q == CNT_W'(1));
            if ((op_q == OP_SHRINK) && (rem_q != CNT_W'(1))) begin
              rem_q  <= rem_q - CNT_W'(1);
              slot_q <= slot_q - SLOT_W'(1);
              state  <= S_PCHK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            rsp.block_number <= emit_blk_q;
            rsp.status       <= emit_st_q;
            rsp.last         <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
